@@ hw/rtl/cms_pkg.sv @@
`default_nettype none

package cms_pkg;

    localparam int ENTRIES        = 16;
    localparam int COUNT_BITS     = 16;
    localparam int IDX_BITS       = $clog2(ENTRIES);
    localparam int KEY_BITS       = 32;
    localparam int OUT_COUNT_BITS = 16;
    localparam int TOTAL_BITS     = 20;
    localparam int OP_BITS        = 2;
    localparam int STATUS_BITS    = 2;

    localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_ABSENT    = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_SATURATED = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the input transaction, restart the scan
        logic scan_step;  // read one entry and advance the scan address
        logic update;     // apply the operation and register the result
    } cms_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;  // scan address sits on the last entry
    } cms_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/cms_ctrl.sv @@
`default_nettype none

module cms_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output cms_pkg::cms_cmd_t      cmd,
    input  wire cms_pkg::cms_stat_t stat
);
    import cms_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free      = !out_valid_reg || m_tready;
    assign s_tready      = (state_reg == ST_IDLE);
    assign m_tvalid      = out_valid_reg;
    assign cmd.load      = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.scan_step = (state_reg == ST_SCAN);
    assign cmd.update    = (state_reg == ST_UPDATE) && out_free;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // hold until the output register is free
                if (out_free) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_update_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!out_valid_reg || m_tready))
        else $error("result registered over an untaken transaction");

    a_load_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (cmd.scan_step && !s_tready))
        else $error("accepted transaction did not start a scan");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && stat.scan_last) |=> !cmd.scan_step)
        else $error("scan ran past the last entry");

    a_update_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> m_tvalid)
        else $error("update did not present a result");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/cms_datapath.sv @@
`default_nettype none

module cms_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire cms_pkg::cms_cmd_t                   cmd,
    output cms_pkg::cms_stat_t                       stat,
    input  wire logic [cms_pkg::OP_BITS-1:0]         in_op,
    input  wire logic [cms_pkg::KEY_BITS-1:0]        in_key,
    output logic [cms_pkg::OUT_COUNT_BITS-1:0]       res_count,
    output logic [cms_pkg::TOTAL_BITS-1:0]           res_total,
    output logic [cms_pkg::STATUS_BITS-1:0]          res_status
);
    import cms_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [KEY_BITS-1:0]   key_mem [ENTRIES];
    logic [COUNT_BITS-1:0] count_reg [ENTRIES];

    logic [OP_BITS-1:0]    op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [IDX_BITS-1:0]   scan_addr_reg;

    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [COUNT_BITS-1:0] rd_count_reg;
    logic [IDX_BITS-1:0]   rd_idx_reg;
    logic                  rd_valid_reg;

    logic                  match_found_reg;
    logic [IDX_BITS-1:0]   match_idx_reg;
    logic [COUNT_BITS-1:0] match_count_reg;
    logic                  free_found_reg;
    logic [IDX_BITS-1:0]   free_idx_reg;

    logic [TOTAL_BITS-1:0] total_reg, total_next;

    logic [OUT_COUNT_BITS-1:0] res_count_reg;
    logic [TOTAL_BITS-1:0]     res_total_reg;
    logic [STATUS_BITS-1:0]    res_status_reg;

    logic                  wr_count_en;
    logic                  wr_key_en;
    logic [IDX_BITS-1:0]   wr_idx;
    logic [COUNT_BITS-1:0] wr_count;
    logic [COUNT_BITS-1:0] new_count;
    logic [STATUS_BITS-1:0] new_status;
    logic [31:0]           count_wide;
    logic [OUT_COUNT_BITS-1:0] count_clip;
    logic                  rd_occupied;

    assign stat.scan_last = (scan_addr_reg == IDX_BITS'(ENTRIES - 1));
    assign rd_occupied    = (rd_count_reg != '0);

    // scan: read one entry per cycle, compare it the cycle after
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_op;
            key_reg <= in_key;
        end
        if (cmd.scan_step) begin
            rd_key_reg   <= key_mem[scan_addr_reg];
            rd_count_reg <= count_reg[scan_addr_reg];
            rd_idx_reg   <= scan_addr_reg;
        end
        if (rd_valid_reg && rd_occupied && !match_found_reg && rd_key_reg == key_reg) begin
            match_idx_reg   <= rd_idx_reg;
            match_count_reg <= rd_count_reg;
        end
        if (rd_valid_reg && !rd_occupied && !free_found_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
        if (wr_key_en) begin
            key_mem[wr_idx] <= key_reg;
        end
        if (cmd.update) begin
            res_count_reg  <= count_clip;
            res_total_reg  <= total_next;
            res_status_reg <= new_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            total_reg       <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            rd_valid_reg <= cmd.scan_step;
            if (cmd.load) begin
                scan_addr_reg   <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end else begin
                if (cmd.scan_step && !stat.scan_last) begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                if (rd_valid_reg && rd_occupied && rd_key_reg == key_reg) begin
                    match_found_reg <= 1'b1;
                end
                if (rd_valid_reg && !rd_occupied) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.update) begin
                total_reg <= total_next;
            end
            if (wr_count_en) begin
                count_reg[wr_idx] <= wr_count;
            end
        end
    end

    // operation outcome from the scan results
    always_comb begin
        wr_count_en = 1'b0;
        wr_key_en   = 1'b0;
        wr_idx      = match_idx_reg;
        wr_count    = match_count_reg;
        new_count   = '0;
        new_status  = STATUS_OK;
        total_next  = total_reg;
        case (op_reg)
            OP_ADD: begin
                if (match_found_reg) begin
                    new_count = match_count_reg;
                    if (match_count_reg == COUNT_MAX) begin
                        new_status = STATUS_SATURATED;
                    end else begin
                        new_count   = match_count_reg + 1'b1;
                        wr_count    = new_count;
                        wr_count_en = cmd.update;
                        total_next  = total_reg + 1'b1;
                    end
                end else if (free_found_reg) begin
                    wr_idx      = free_idx_reg;
                    new_count   = COUNT_BITS'(1);
                    wr_count    = new_count;
                    wr_count_en = cmd.update;
                    wr_key_en   = cmd.update;
                    total_next  = total_reg + 1'b1;
                end else begin
                    new_status = STATUS_FULL;
                end
            end
            OP_REMOVE: begin
                if (match_found_reg) begin
                    new_count   = match_count_reg - 1'b1;
                    wr_count    = new_count;
                    wr_count_en = cmd.update;
                    total_next  = total_reg - 1'b1;
                end else begin
                    new_status = STATUS_ABSENT;
                end
            end
            default: begin
                // query, and the unused code acting as one
                if (match_found_reg) begin
                    new_count = match_count_reg;
                end
            end
        endcase
    end

    assign count_wide = 32'(new_count);
    assign count_clip = (count_wide > 32'(COUNT_MAX_OUT())) ? '1
                                                             : count_wide[OUT_COUNT_BITS-1:0];

    function automatic logic [OUT_COUNT_BITS-1:0] COUNT_MAX_OUT();
        return '1;
    endfunction

    assign res_count  = res_count_reg;
    assign res_total  = res_total_reg;
    assign res_status = res_status_reg;

`ifndef SYNTHESIS
    a_free_only_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_key_en |-> !match_found_reg)
        else $error("new entry claimed for a value already held");

    a_total_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.update |=> $stable(total_reg))
        else $error("running total moved outside an update");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && new_status == STATUS_FULL) |-> (!free_found_reg && !match_found_reg))
        else $error("table full reported with a usable entry");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/counting_multiset_table.sv @@
// Counting multiset table: one transaction in, one result out.
// From input acceptance to m_tvalid: 16 entry reads of the key memory, one entry per
// cycle, then one compare drain step and one update step, which waits for a free
// output register; no new transaction is taken until that update is done.
// A new input is taken while the previous result still waits on m_tready.
// Reset (aresetn low, synchronous) frees every entry and clears the total.
`default_nettype none

module counting_multiset_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] item_value
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [15:0] item_count, [35:16] total_count, zero fill
    output logic [1:0]       m_tuser    // [1:0] status
);
    import cms_pkg::*;

    cms_cmd_t  cmd;
    cms_stat_t stat;

    logic [OUT_COUNT_BITS-1:0] res_count;
    logic [TOTAL_BITS-1:0]     res_total;
    logic [STATUS_BITS-1:0]    res_status;

    cms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cms_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_key     (s_tdata),
        .res_count  (res_count),
        .res_total  (res_total),
        .res_status (res_status)
    );

    assign m_tdata = {4'b0000, res_total, res_count};
    assign m_tuser = res_status;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none

module testbench;

    import cms_pkg::*;

    // Operation code 3 has no name in the package; the block treats it as a query
    localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int POOL_SIZE      = 24;
    localparam int PHASE_ITEMS    = 100;
    localparam int PLAN_LEN       = 19;

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    typedef struct packed {
        logic [OUT_COUNT_BITS-1:0] count;
        logic [TOTAL_BITS-1:0]     total;
        logic [STATUS_BITS-1:0]    status;
    } tally_t;

    typedef struct packed {
        logic [OP_BITS-1:0]  op;
        logic [KEY_BITS-1:0] value;
        logic [16:0]         reps;
        logic [KEY_BITS-1:0] stride;
        logic                typed;
        tally_t              want;
    } plan_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_QUERY;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    // Shadow copy of the table
    logic [KEY_BITS-1:0]   shadow_keys   [ENTRIES];
    logic [COUNT_BITS-1:0] shadow_counts [ENTRIES];
    logic [TOTAL_BITS-1:0] shadow_total;

    tally_t pending_tallies[$];
    int     mismatches    = 0;
    int     send_idle_pct = 0;
    int     stall_pct     = 0;

    // Directed sequence: typed results from an empty table, through a full table
    // and back
    plan_row_t plan [PLAN_LEN] = '{
        '{OP_QUERY,  32'h0000_0000, 17'd1, 32'd0, 1'b1, '{16'd0, 20'd0, STATUS_OK}},
        '{OP_REMOVE, 32'h7FFF_FFFF, 17'd1, 32'd0, 1'b1, '{16'd0, 20'd0, STATUS_ABSENT}},
        '{OP_ADD,    32'h8000_0000, 17'd1, 32'd0, 1'b1, '{16'd1, 20'd1, STATUS_OK}},
        '{OP_ADD,    32'h7FFF_FFFF, 17'd1, 32'd0, 1'b1, '{16'd1, 20'd2, STATUS_OK}},
        '{OP_ADD,    32'h0000_0000, 17'd1, 32'd0, 1'b1, '{16'd1, 20'd3, STATUS_OK}},
        '{OP_ADD,    32'h0000_0000, 17'd1, 32'd0, 1'b1, '{16'd2, 20'd4, STATUS_OK}},
        '{OP_QUERY,  32'h8000_0000, 17'd1, 32'd0, 1'b1, '{16'd1, 20'd4, STATUS_OK}},
        '{OP_REMOVE, 32'h8000_0000, 17'd1, 32'd0, 1'b1, '{16'd0, 20'd3, STATUS_OK}},
        '{OP_QUERY,  32'h8000_0000, 17'd1, 32'd0, 1'b1, '{16'd0, 20'd3, STATUS_OK}},
        '{OP_SPARE,  32'h7FFF_FFFF, 17'd1, 32'd0, 1'b1, '{16'd1, 20'd3, STATUS_OK}},
        '{OP_ADD,    32'hFFFF_FFFF, 17'd1, 32'd0, 1'b1, '{16'd1, 20'd4, STATUS_OK}},
        '{OP_ADD,    32'h5555_5555, 17'd13, 32'd1, 1'b0, '0},
        '{OP_ADD,    32'hAAAA_AAAA, 17'd1, 32'd0, 1'b1, '{16'd0, 20'd17, STATUS_FULL}},
        '{OP_REMOVE, 32'hAAAA_AAAA, 17'd1, 32'd0, 1'b1, '{16'd0, 20'd17, STATUS_ABSENT}},
        '{OP_ADD,    32'h0000_0000, 17'd1, 32'd0, 1'b1, '{16'd3, 20'd18, STATUS_OK}},
        '{OP_REMOVE, 32'h5555_5555, 17'd1, 32'd0, 1'b1, '{16'd0, 20'd17, STATUS_OK}},
        '{OP_ADD,    32'hAAAA_AAAA, 17'd1, 32'd0, 1'b1, '{16'd1, 20'd18, STATUS_OK}},
        '{OP_REMOVE, 32'hFFFF_FFFF, 17'd1, 32'd0, 1'b1, '{16'd0, 20'd17, STATUS_OK}},
        '{OP_QUERY,  32'h0000_0000, 17'd1, 32'd0, 1'b0, '0}
    };

    counting_multiset_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] item_value
        .s_tuser  (s_tuser),   // [1:0] operation
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [15:0] item_count, [35:16] total_count, zero fill
        .m_tuser  (m_tuser)    // [1:0] status
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Apply one operation to the shadow table and return the result it gives
    function automatic tally_t apply_operation(logic [OP_BITS-1:0] op,
                                               logic [KEY_BITS-1:0] value);
        tally_t                result;
        int                    hit;
        int                    slot;
        logic [COUNT_BITS-1:0] n;
        hit    = -1;
        slot   = -1;
        n      = '0;
        result = '0;
        result.status = STATUS_OK;
        // scan downwards so the lowest free entry wins
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (shadow_counts[i] != 0 && shadow_keys[i] == value) hit = i;
            if (shadow_counts[i] == 0) slot = i;
        end
        case (op)
            OP_ADD: begin
                if (hit >= 0) begin
                    if (shadow_counts[hit] == COUNT_FULL) begin
                        result.status = STATUS_SATURATED;
                    end else begin
                        shadow_counts[hit] = shadow_counts[hit] + 1'b1;
                        shadow_total       = shadow_total + 1'b1;
                    end
                    n = shadow_counts[hit];
                end else if (slot < 0) begin
                    result.status = STATUS_FULL;
                end else begin
                    shadow_keys[slot]   = value;
                    shadow_counts[slot] = COUNT_BITS'(1);
                    shadow_total        = shadow_total + 1'b1;
                    n = COUNT_BITS'(1);
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    shadow_counts[hit] = shadow_counts[hit] - 1'b1;
                    shadow_total       = shadow_total - 1'b1;
                    n = shadow_counts[hit];
                end else begin
                    result.status = STATUS_ABSENT;
                end
            end
            default: begin
                if (hit >= 0) n = shadow_counts[hit];
            end
        endcase
        if (n > (2 ** OUT_COUNT_BITS - 1)) result.count = '1;
        else result.count = OUT_COUNT_BITS'(n);
        result.total = shadow_total;
        return result;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Hold tvalid high across back-to-back transactions; drop it only for a gap
    task automatic send_item(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] value,
                             logic typed, tally_t want);
        tally_t predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predicted = apply_operation(op, value);
        pending_tallies.push_back(typed ? want : predicted);
    endtask

    initial begin : result_check
        tally_t got;
        tally_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.count  = m_tdata[15:0];
                got.total  = m_tdata[35:16];
                got.status = m_tuser;
                if (m_tdata[39:36] != 0) report_mismatch("fill bits", m_tdata[39:36], 0);
                if (pending_tallies.size() == 0) begin
                    report_mismatch("unexpected result", got, 0);
                end else begin
                    want = pending_tallies.pop_front();
                    if (got.count != want.count)
                        report_mismatch("item_count", got.count, want.count);
                    if (got.total != want.total)
                        report_mismatch("total_count", got.total, want.total);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        logic [KEY_BITS-1:0] pool [POOL_SIZE];
        int                  idle_plan  [5] = '{0, 80, 0, 20, 0};
        int                  stall_plan [5] = '{0, 0, 80, 20, 0};
        logic [OP_BITS-1:0]  op;
        logic [KEY_BITS-1:0] value;
        int                  pick;

        for (int i = 0; i < ENTRIES; i++) begin
            shadow_keys[i]   = '0;
            shadow_counts[i] = '0;
        end
        shadow_total = '0;
        foreach (pool[i]) pool[i] = $urandom;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[r]) begin
            for (int k = 0; k < plan[r].reps; k++)
                send_item(plan[r].op, plan[r].value + k * plan[r].stride,
                          plan[r].typed, plan[r].want);
        end

        // Favour a small pool of values so that adds and removes keep meeting
        for (int p = 0; p < 5; p++) begin
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 45) op = OP_ADD;
                else if (pick < 80) op = OP_REMOVE;
                else if (pick < 95) op = OP_QUERY;
                else op = OP_SPARE;
                if ($urandom_range(99) < 70) value = pool[$urandom_range(POOL_SIZE - 1)];
                else value = $urandom;
                send_item(op, value, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_tallies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
